FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the permuter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/ipip_pkg.sv
// Package of the inverse power index permuter: widths, codes and unit command type.
package ipip_pkg;

  localparam int unsigned MaxRowsDef = 31;
  localparam int unsigned ModBitsDef = 31;

  localparam int unsigned DataW  = 31;
  localparam int unsigned TotalW = 32;
  localparam int unsigned RowW   = 5;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned Steps  = DataW;
  localparam int unsigned CntW   = 5;

  localparam logic [StatW-1:0] StOk      = 3'd0;
  localparam logic [StatW-1:0] StRow     = 3'd1;
  localparam logic [StatW-1:0] StCol     = 3'd2;
  localparam logic [StatW-1:0] StUnbuilt = 3'd3;
  localparam logic [StatW-1:0] StNoInv   = 3'd4;

  localparam logic [CfgIdxW-1:0] RegModulus = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTotal   = 2'd1;

  localparam logic ReqBuild  = 1'b0;
  localparam logic ReqLookup = 1'b1;

  typedef enum logic {
    OP_MULMOD,
    OP_DIV
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_cmd_t;

endpackage

FILE: rtl/ipip_req_if.sv
// Request and response channel interfaces of the permuter.
interface ipip_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ipip_pkg::RowW-1:0]    row_index;
  logic [ipip_pkg::DataW-1:0]   dst_exponent;

  modport source (output valid, req_type, row_index, dst_exponent, input ready);
  modport sink (input valid, req_type, row_index, dst_exponent, output ready);
endinterface

interface ipip_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ipip_pkg::TotalW-1:0]  out_value;
  logic [ipip_pkg::StatW-1:0]   status;

  modport source (output valid, out_value, status, input ready);
  modport sink (input valid, out_value, status, output ready);
endinterface

FILE: rtl/ipip_arith.sv
// Shared bit-serial unit: modular multiply by double-and-add, or restoring division.
module ipip_arith (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ipip_pkg::arith_cmd_t        cmd_i,
  input  logic [ipip_pkg::DataW-1:0]  opa_i,
  input  logic [ipip_pkg::DataW-1:0]  opb_i,
  input  logic [ipip_pkg::DataW-1:0]  mod_i,
  output logic                        done_o,
  output logic [ipip_pkg::DataW-1:0]  acc_o,
  output logic [ipip_pkg::DataW-1:0]  quo_o
);

  localparam int unsigned W = ipip_pkg::DataW;

  logic                           busy_q, done_q;
  logic [ipip_pkg::CntW-1:0]      cnt_q;
  ipip_pkg::arith_op_e            op_q;
  logic [W:0]                     acc_q, acc_d;
  logic [W-1:0]                   mq_q, mq_d;
  logic [W-1:0]                   b_q, p_q;
  logic [W:0]                     dbl, sum, rem;
  logic                           ge;

  always_comb begin
    dbl = {acc_q[W-1:0], 1'b0};
    if (dbl >= {1'b0, p_q}) begin
      dbl = dbl - {1'b0, p_q};
    end
    sum = dbl + (mq_q[W-1] ? {1'b0, b_q} : '0);
    if (sum >= {1'b0, p_q}) begin
      sum = sum - {1'b0, p_q};
    end
    rem = {acc_q[W-1:0], mq_q[W-1]};
    ge  = (rem >= {1'b0, b_q});
    case (op_q)
      ipip_pkg::OP_MULMOD: begin
        acc_d = sum;
        mq_d  = {mq_q[W-2:0], 1'b0};
      end
      ipip_pkg::OP_DIV: begin
        acc_d = ge ? (rem - {1'b0, b_q}) : rem;
        mq_d  = {mq_q[W-2:0], ge};
      end
      default: begin
        acc_d = acc_q;
        mq_d  = mq_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ipip_pkg::CntW'(ipip_pkg::Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      acc_q <= '0;
      mq_q  <= opa_i;
      b_q   <= opb_i;
      p_q   <= mod_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mq_q  <= mq_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q[W-1:0];
  assign quo_o  = mq_q;

endmodule

FILE: rtl/inverse_power_index_permuter.sv
// Top level: request sequencer, factor store and configuration registers.
// A lookup is one 31-step modular multiply between acceptance and response.
// A build of row i takes i squarings, then Euclid steps that are each a 31-step
// division and a 31-step multiply.
// Errors found at acceptance are offered the cycle after it. One request is in flight;
// ready is low meanwhile. Reset clears the built bits and sets modulus 3 and total 64.
`include "assert_macros.svh"

module inverse_power_index_permuter #(
  parameter int unsigned MAX_ROWS = ipip_pkg::MaxRowsDef,
  parameter int unsigned MOD_BITS = ipip_pkg::ModBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipip_pkg::TotalW-1:0]   cfg_data_i,
  ipip_req_if.sink                      req_i,
  ipip_rsp_if.source                    rsp_o
);

  localparam int unsigned W  = ipip_pkg::DataW;
  localparam int unsigned TW = ipip_pkg::TotalW;
  localparam int unsigned RW = $clog2(MAX_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SQW, S_EU, S_DIVW, S_MULW, S_LKW, S_OUT
  } state_e;

  state_e                       state_q;
  logic [MOD_BITS-1:0]          mod_q;
  logic [TW-1:0]                total_q;
  logic [MAX_ROWS-1:0]          built_q;
  logic [W-1:0]                 factor_mem [MAX_ROWS];
  logic [ipip_pkg::RowW-1:0]    row_q, cnt_q;
  logic [W-1:0]                 v_q, r0_q, r1_q, t0_q, t1_q;
  logic [W-1:0]                 opa_q, opb_q;
  ipip_pkg::arith_cmd_t         cmd_q;
  logic [TW-1:0]                value_q;
  logic [ipip_pkg::StatW-1:0]   status_q;

  logic [W-1:0]                 p, acc, quo, t2;
  logic                         done, accept, row_ok, store_we;

  assign p      = W'(mod_q);
  assign accept = req_i.valid && req_i.ready;
  assign row_ok = (32'(req_i.row_index) < MAX_ROWS) && ((p >> req_i.row_index) != '0);
  assign t2     = (t0_q >= acc) ? (t0_q - acc) : W'({1'b0, t0_q} + {1'b0, p} - {1'b0, acc});
  assign store_we = (state_q == S_EU) && (r1_q == '0) && (r0_q == W'(1));

  ipip_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .opa_i  (opa_q),
    .opb_i  (opb_q),
    .mod_i  (p),
    .done_o (done),
    .acc_o  (acc),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_BITS'(3);
      total_q <= TW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipip_pkg::RegModulus: mod_q   <= cfg_data_i[MOD_BITS-1:0];
        ipip_pkg::RegTotal:   total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      factor_mem[row_q[RW-1:0]] <= t0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      built_q  <= '0;
      cmd_q    <= '0;
      value_q  <= '0;
      status_q <= ipip_pkg::StOk;
      row_q <= '0; cnt_q <= '0; v_q <= '0;
      r0_q <= '0; r1_q <= '0; t0_q <= '0; t1_q <= '0;
      opa_q <= '0; opb_q <= '0;
    end else begin
      ipip_pkg::arith_cmd_t cmd_d;
      // The start bit of the unit command is a one-cycle pulse.
      cmd_d = '{start: 1'b0, op: cmd_q.op};
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            row_q    <= req_i.row_index;
            value_q  <= '0;
            cnt_q    <= '0;
            if (!row_ok) begin
              status_q <= ipip_pkg::StRow;
              state_q  <= S_OUT;
            end else if (req_i.req_type == ipip_pkg::ReqBuild) begin
              status_q <= ipip_pkg::StOk;
              v_q      <= (p > W'(2)) ? W'(2) : '0;
              state_q  <= S_SQ;
            end else if (!built_q[req_i.row_index[RW-1:0]]) begin
              status_q <= ipip_pkg::StUnbuilt;
              state_q  <= S_OUT;
            end else if ((req_i.dst_exponent >= p) ||
                         ({1'b0, req_i.dst_exponent} >= total_q)) begin
              status_q <= ipip_pkg::StCol;
              state_q  <= S_OUT;
            end else begin
              status_q <= ipip_pkg::StOk;
              opa_q    <= factor_mem[req_i.row_index[RW-1:0]];
              opb_q    <= req_i.dst_exponent;
              cmd_d    = '{start: 1'b1, op: ipip_pkg::OP_MULMOD};
              state_q  <= S_LKW;
            end
          end
        end
        S_SQ: begin
          if (cnt_q == row_q) begin
            if (v_q == '0) begin
              built_q[row_q[RW-1:0]] <= 1'b0;
              status_q <= ipip_pkg::StNoInv;
              state_q  <= S_OUT;
            end else begin
              r0_q <= p; r1_q <= v_q; t0_q <= '0; t1_q <= W'(1);
              state_q <= S_EU;
            end
          end else begin
            opa_q   <= v_q;
            opb_q   <= v_q;
            cmd_d   = '{start: 1'b1, op: ipip_pkg::OP_MULMOD};
            state_q <= S_SQW;
          end
        end
        S_SQW: begin
          if (done) begin
            v_q     <= acc;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_SQ;
          end
        end
        S_EU: begin
          if (r1_q == '0) begin
            if (r0_q == W'(1)) begin
              built_q[row_q[RW-1:0]] <= 1'b1;
              value_q <= TW'(t0_q);
            end else begin
              built_q[row_q[RW-1:0]] <= 1'b0;
              status_q <= ipip_pkg::StNoInv;
            end
            state_q <= S_OUT;
          end else begin
            opa_q   <= r0_q;
            opb_q   <= r1_q;
            cmd_d   = '{start: 1'b1, op: ipip_pkg::OP_DIV};
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (done) begin
            r0_q    <= r1_q;
            r1_q    <= acc;
            opa_q   <= quo;
            opb_q   <= t1_q;
            cmd_d   = '{start: 1'b1, op: ipip_pkg::OP_MULMOD};
            state_q <= S_MULW;
          end
        end
        S_MULW: begin
          // The coefficients are kept as residues mod p, so the final one is the inverse.
          if (done) begin
            t0_q    <= t1_q;
            t1_q    <= t2;
            state_q <= S_EU;
          end
        end
        S_LKW: begin
          if (done) begin
            if (TW'(acc) >= total_q) begin
              status_q <= ipip_pkg::StCol;
            end else begin
              value_q <= total_q - TW'(1) - TW'(acc);
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      cmd_q <= cmd_d;
    end
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = (state_q == S_OUT);
  assign rsp_o.out_value = value_q;
  assign rsp_o.status    = status_q;

  `ASSERT_NEXT(a_busy_after_accept, accept, !req_i.ready)
  `ASSERT_SAME(a_done_when_waiting, done,
    state_q == S_SQW || state_q == S_DIVW || state_q == S_MULW || state_q == S_LKW)
  `ASSERT_SAME(a_error_value_zero, rsp_o.valid && rsp_o.status != ipip_pkg::StOk,
    rsp_o.out_value == '0)
  `ASSERT_SAME(a_store_on_unit_gcd, store_we, r0_q == W'(1) && t0_q < p)

endmodule
